### design/tld_pkg.sv
`default_nettype none

package tld_pkg;

	localparam logic OP_RX   = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	localparam logic [1:0] MODE_RAW    = 2'd0;
	localparam logic [1:0] MODE_CBREAK = 2'd1;

	localparam logic [2:0] CFG_MODE  = 3'd0;
	localparam logic [2:0] CFG_FLAGS = 3'd1;
	localparam logic [2:0] CFG_INTR  = 3'd2;
	localparam logic [2:0] CFG_KILL  = 3'd3;
	localparam logic [2:0] CFG_ERASE = 3'd4;
	localparam logic [2:0] CFG_EOF   = 3'd5;
	localparam logic [2:0] CFG_FULL  = 3'd6;

	localparam int unsigned FL_CRMAP  = 0;
	localparam int unsigned FL_INTR   = 1;
	localparam int unsigned FL_ECHO   = 2;
	localparam int unsigned FL_KILL   = 3;
	localparam int unsigned FL_ERASE  = 4;
	localparam int unsigned FL_EOF    = 5;
	localparam int unsigned FL_EBLANK = 6;
	localparam int unsigned FL_VIS    = 7;
	localparam int unsigned FL_ECRLF  = 8;

	localparam logic [1:0] RST_MODE  = 2'd2;
	localparam logic [8:0] RST_FLAGS = 9'h1FF;
	localparam logic [7:0] RST_INTR  = 8'd3;
	localparam logic [7:0] RST_KILL  = 8'd21;
	localparam logic [7:0] RST_ERASE = 8'd8;
	localparam logic [7:0] RST_EOF   = 8'd4;
	localparam logic [7:0] RST_FULL  = 8'd7;

	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_NL  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_SP  = 8'd32;
	localparam logic [7:0] CH_UP  = 8'd94;
	localparam logic [7:0] CH_DEL = 8'd127;

	localparam logic [7:0] CTL_OFFSET = 8'o100;
	localparam logic [7:0] CTL_MASK   = 8'o177;

	localparam logic [1:0] K_TAKE  = 2'd0;
	localparam logic [1:0] K_ERASE = 2'd1;
	localparam logic [1:0] K_KILL  = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [8:0] flags;
		logic [7:0] intr_ch;
		logic [7:0] kill_ch;
		logic [7:0] erase_ch;
		logic [7:0] eof_ch;
		logic [7:0] full_ch;
	} cfg_t;

	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} echo_pair_t;

	typedef struct packed {
		logic [2:0]      cnt;
		logic [5:0][7:0] b;
	} echo_t;

	typedef struct packed {
		echo_t      echo;
		logic       interrupt;
		logic       read_valid;
		logic [7:0] read_char;
		logic       last;
	} res_t;

	function automatic logic is_ctl(logic [7:0] c);
		return (c < CH_SP) || (c == CH_DEL);
	endfunction

	function automatic echo_pair_t echo_char(logic [7:0] c, logic ecrlf, logic vis);
		echo_pair_t p;
		p = '0;
		if ((c == CH_NL || c == CH_CR) && ecrlf) begin
			p.cnt = 2'd2;
			p.b0  = CH_CR;
			p.b1  = CH_NL;
		end else if (is_ctl(c) && vis) begin
			p.cnt = 2'd2;
			p.b0  = CH_UP;
			p.b1  = (c + CTL_OFFSET) & CTL_MASK;
		end else begin
			p.cnt = 2'd1;
			p.b0  = c;
		end
		return p;
	endfunction

	// q follows p; unused bytes of both are zero
	function automatic echo_t echo_join(echo_pair_t p, echo_pair_t q);
		echo_t e;
		e = '0;
		e.b[0] = p.b0;
		if (p.cnt == 2'd2) begin
			e.b[1] = p.b1;
			e.b[2] = q.b0;
			e.b[3] = q.b1;
		end else begin
			e.b[1] = q.b0;
			e.b[2] = q.b1;
		end
		e.cnt = 3'(p.cnt) + 3'(q.cnt);
		return e;
	endfunction

	function automatic echo_t erase_echo(logic ctl, logic vis, logic blank);
		echo_t e;
		e = '0;
		if (blank) begin
			e.b[0] = CH_BS;
			e.b[1] = CH_SP;
			e.b[2] = CH_BS;
			e.cnt  = 3'd3;
			if (ctl && vis) begin
				e.b[3] = CH_BS;
				e.b[4] = CH_SP;
				e.b[5] = CH_BS;
				e.cnt  = 3'd6;
			end
		end else begin
			e.b[0] = CH_BS;
			e.cnt  = 3'd1;
			if (ctl && vis) begin
				e.b[1] = CH_BS;
				e.cnt  = 3'd2;
			end
		end
		return e;
	endfunction

endpackage

`default_nettype wire

### design/terminal_line_discipline.sv
`default_nettype none

// Keyboard line discipline over a ring buffer of BUF_DEPTH bytes held in a
// synchronous memory with one write and one read port. Items are taken one
// at a time: in_stall is high from acceptance until the item's last result
// is loaded into the output register. An item with no buffer read (a
// received byte that erases nothing, or a take on an empty buffer) passes
// through S_EXEC alone; a take of a byte or an erase of one character also
// passes through S_RDATA, for the memory read.
// A kill gives one result per erased character, paced by the read port,
// one per cycle unless the output stalls, which holds the sequencer. The
// output register frees the input side as soon as a result is parked there.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only be changed while the block is idle.
module terminal_line_discipline #(
	parameter int unsigned BUF_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       operation,
	input  wire logic [7:0] rx_char,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [2:0] echo_count,
	output logic      [7:0] echo_byte0,
	output logic      [7:0] echo_byte1,
	output logic      [7:0] echo_byte2,
	output logic      [7:0] echo_byte3,
	output logic      [7:0] echo_byte4,
	output logic      [7:0] echo_byte5,
	output logic            interrupt,
	output logic            read_valid,
	output logic      [7:0] read_char,
	output logic            last,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [8:0] cfg_data
);

	import tld_pkg::*;

	localparam int unsigned IDX_W = $clog2(BUF_DEPTH);
	localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);

	cfg_t             cfg_q;
	res_t             res;
	logic             mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	logic [7:0]       mem_wr_data;
	logic             mem_rd_en;
	logic [IDX_W-1:0] mem_rd_addr;
	logic [7:0]       mem_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= RST_MODE;
			cfg_q.flags    <= RST_FLAGS;
			cfg_q.intr_ch  <= RST_INTR;
			cfg_q.kill_ch  <= RST_KILL;
			cfg_q.erase_ch <= RST_ERASE;
			cfg_q.eof_ch   <= RST_EOF;
			cfg_q.full_ch  <= RST_FULL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:  cfg_q.mode     <= cfg_data[1:0];
				CFG_FLAGS: cfg_q.flags    <= cfg_data;
				CFG_INTR:  cfg_q.intr_ch  <= cfg_data[7:0];
				CFG_KILL:  cfg_q.kill_ch  <= cfg_data[7:0];
				CFG_ERASE: cfg_q.erase_ch <= cfg_data[7:0];
				CFG_EOF:   cfg_q.eof_ch   <= cfg_data[7:0];
				CFG_FULL:  cfg_q.full_ch  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	tld_seq #(
		.BUF_DEPTH(BUF_DEPTH),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.rx_char(rx_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res(res),
		.mem_wr_en(mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en(mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	tld_ring #(
		.BUF_DEPTH(BUF_DEPTH),
		.IDX_W(IDX_W)
	) u_ring (
		.clk(clk),
		.wr_en(mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en(mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	assign echo_count = res.echo.cnt;
	assign echo_byte0 = res.echo.b[0];
	assign echo_byte1 = res.echo.b[1];
	assign echo_byte2 = res.echo.b[2];
	assign echo_byte3 = res.echo.b[3];
	assign echo_byte4 = res.echo.b[4];
	assign echo_byte5 = res.echo.b[5];
	assign interrupt  = res.interrupt;
	assign read_valid = res.read_valid;
	assign read_char  = res.read_char;
	assign last       = res.last;

endmodule

`default_nettype wire

### design/tld_ring.sv
`default_nettype none

module tld_ring #(
	parameter int unsigned BUF_DEPTH = 64,
	parameter int unsigned IDX_W     = 6
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire logic [7:0]       wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output logic      [7:0]       rd_data
);

	logic [7:0] mem [BUF_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### design/tld_seq.sv
`default_nettype none

module tld_seq #(
	parameter int unsigned BUF_DEPTH = 64,
	parameter int unsigned IDX_W     = 6,
	parameter int unsigned CNT_W     = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tld_pkg::cfg_t     cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              operation,
	input  wire logic [7:0]        rx_char,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output tld_pkg::res_t          res,
	output logic                   mem_wr_en,
	output logic      [IDX_W-1:0]  mem_wr_addr,
	output logic      [7:0]        mem_wr_data,
	output logic                   mem_rd_en,
	output logic      [IDX_W-1:0]  mem_rd_addr,
	input  wire logic [7:0]        mem_rd_data
);

	import tld_pkg::*;

	localparam int unsigned SUM_W = CNT_W + 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUF_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUF_DEPTH);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_RDATA = 2'd2;

	logic [1:0]       state_q;
	logic             op_q;
	logic [7:0]       ch_q;
	logic [1:0]       kind_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] cc_q;
	logic [IDX_W-1:0] cur_q;
	logic             out_valid_q;
	res_t             res_q;

	logic             accept;
	logic             out_free;
	logic [7:0]       cm;
	logic [IDX_W-1:0] head_inc;
	logic [IDX_W-1:0] head_dec;
	logic [IDX_W-1:0] head_dec2;
	logic [IDX_W-1:0] tail_inc;
	logic [SUM_W-1:0] sum;
	echo_pair_t       ec;
	echo_pair_t       nl_pair;
	echo_t            ee;

	logic             ex_rd;
	logic [1:0]       ex_kind;
	logic             ex_store;
	logic [7:0]       ex_wdata;
	logic [CNT_W-1:0] ex_cc;
	logic [IDX_W-1:0] ex_cur;
	res_t             ex_res;

	logic             rd_more;
	res_t             rd_res;
	logic             exec_load;
	logic             rdata_load;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	assign cm = (ch_q == CH_CR && cfg.flags[FL_CRMAP]) ? CH_NL : ch_q;

	assign head_inc  = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign head_dec  = (head_q == '0) ? IDX_LAST : head_q - 1'b1;
	assign head_dec2 = (head_dec == '0) ? IDX_LAST : head_dec - 1'b1;
	assign tail_inc  = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
	assign sum       = SUM_W'(cc_q) + SUM_W'(cur_q);

	assign ec      = echo_char(cm, cfg.flags[FL_ECRLF], cfg.flags[FL_VIS]);
	assign nl_pair = echo_char(CH_NL, cfg.flags[FL_ECRLF], cfg.flags[FL_VIS]);
	assign ee      = cfg.flags[FL_ECHO]
		? erase_echo(is_ctl(mem_rd_data), cfg.flags[FL_VIS], cfg.flags[FL_EBLANK])
		: '0;

	// decision for the held item, no buffer data needed
	always_comb begin
		ex_rd    = 1'b0;
		ex_kind  = K_TAKE;
		ex_store = 1'b0;
		ex_wdata = cm;
		ex_cc    = cc_q;
		ex_cur   = cur_q;
		ex_res   = '0;
		ex_res.last = 1'b1;
		if (op_q == OP_TAKE) begin
			if (cc_q != '0) begin
				ex_rd = 1'b1;
			end
		end else if (cfg.mode == MODE_RAW) begin
			ex_wdata = ch_q;
			if (cc_q != CNT_FULL) begin
				ex_store = 1'b1;
				ex_cc    = cc_q + 1'b1;
			end
		end else if (cfg.flags[FL_INTR] && cm == cfg.intr_ch) begin
			ex_res.echo      = echo_join(ec, '0);
			ex_res.interrupt = 1'b1;
		end else if (cfg.mode == MODE_CBREAK) begin
			if (cc_q == CNT_FULL) begin
				ex_res.echo = echo_join('{cnt: 2'd1, b0: cfg.full_ch, b1: 8'd0}, '0);
			end else begin
				ex_store = 1'b1;
				ex_cc    = cc_q + 1'b1;
				if (cfg.flags[FL_ECHO]) begin
					ex_res.echo = echo_join(ec, '0);
				end
			end
		end else if (cm == cfg.kill_ch && cfg.flags[FL_KILL]) begin
			if (cur_q != '0) begin
				ex_rd   = 1'b1;
				ex_kind = K_KILL;
			end
		end else if (cm == cfg.erase_ch && cfg.flags[FL_ERASE]) begin
			if (cur_q != '0) begin
				ex_rd   = 1'b1;
				ex_kind = K_ERASE;
			end
		end else if (cm == CH_NL || cm == CH_CR || (cm == cfg.eof_ch && cfg.flags[FL_EOF])) begin
			if (sum >= SUM_W'(BUF_DEPTH)) begin
				ex_res.echo = echo_join('{cnt: 2'd1, b0: cfg.full_ch, b1: 8'd0}, '0);
			end else begin
				if (cfg.flags[FL_ECHO]) begin
					ex_res.echo = echo_join(ec, (cm == cfg.eof_ch) ? nl_pair : '0);
				end
				ex_store = 1'b1;
				ex_cc    = CNT_W'(sum + 1'b1);
				ex_cur   = '0;
			end
		end else begin
			if (sum >= SUM_W'(BUF_DEPTH - 1)) begin
				ex_res.echo = echo_join('{cnt: 2'd1, b0: cfg.full_ch, b1: 8'd0}, '0);
			end else begin
				if (cfg.flags[FL_ECHO]) begin
					ex_res.echo = echo_join(ec, '0);
				end
				ex_store = 1'b1;
				ex_cur   = cur_q + 1'b1;
			end
		end
	end

	// result once buffer data is in
	always_comb begin
		rd_res  = '0;
		rd_more = 1'b0;
		if (kind_q == K_TAKE) begin
			rd_res.read_valid = 1'b1;
			rd_res.read_char  = mem_rd_data;
			rd_res.last       = 1'b1;
		end else begin
			rd_res.echo = ee;
			rd_more     = (kind_q == K_KILL) && (cur_q != IDX_W'(1));
			rd_res.last = !rd_more;
		end
	end

	assign exec_load  = (state_q == S_EXEC) && !ex_rd && out_free;
	assign rdata_load = (state_q == S_RDATA) && out_free;

	// sequential, so a read never meets a write to the same entry
	assign mem_wr_en   = exec_load && ex_store;
	assign mem_wr_addr = head_q;
	assign mem_wr_data = ex_wdata;
	assign mem_rd_en   = ((state_q == S_EXEC) && ex_rd) || (rdata_load && rd_more);
	assign mem_rd_addr = (state_q == S_EXEC)
		? ((op_q == OP_TAKE) ? tail_q : head_dec)
		: head_dec2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cc_q        <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_load || rdata_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ex_rd) begin
						state_q <= S_RDATA;
					end else if (out_free) begin
						cc_q  <= ex_cc;
						cur_q <= ex_cur;
						if (ex_store) begin
							head_q <= head_inc;
						end
						state_q <= S_IDLE;
					end
				end
				S_RDATA: begin
					if (out_free) begin
						if (kind_q == K_TAKE) begin
							tail_q <= tail_inc;
							cc_q   <= cc_q - 1'b1;
						end else begin
							head_q <= head_dec;
							cur_q  <= cur_q - 1'b1;
						end
						if (!rd_more) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			ch_q <= rx_char;
		end
		if (state_q == S_EXEC && ex_rd) begin
			kind_q <= ex_kind;
		end
		if (exec_load) begin
			res_q <= ex_res;
		end else if (rdata_load) begin
			res_q <= rd_res;
		end
	end

endmodule

`default_nettype wire

### tb/sv/tld_checker.sv
module tld_checker
	import tld_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       operation,
	input  logic [7:0] rx_char,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] echo_count,
	input  logic [7:0] echo_byte0,
	input  logic [7:0] echo_byte1,
	input  logic [7:0] echo_byte2,
	input  logic [7:0] echo_byte3,
	input  logic [7:0] echo_byte4,
	input  logic [7:0] echo_byte5,
	input  logic       interrupt,
	input  logic       read_valid,
	input  logic [7:0] read_char,
	input  logic       last,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data,
	output int         pending,
	output int         failures
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  ring [DEPTH];
	int unsigned head;
	int unsigned tail;
	int unsigned committed;
	int unsigned cursor;
	cfg_t        settings;
	echo_t       echo_now;
	res_t        due_results[$];
	int          results_seen;

	function automatic logic control_byte(logic [7:0] c);
		return (c < CH_SP) || (c == CH_DEL);
	endfunction

	function automatic int unsigned step_on(int unsigned i);
		return (i + 1 >= DEPTH) ? 0 : i + 1;
	endfunction

	function void put_echo(logic [7:0] b);
		if (echo_now.cnt < 3'd6) begin
			echo_now.b[echo_now.cnt] = b;
			echo_now.cnt = echo_now.cnt + 3'd1;
		end
	endfunction

	function void echo_key(logic [7:0] c);
		if ((c == CH_NL || c == CH_CR) && settings.flags[FL_ECRLF]) begin
			put_echo(CH_CR);
			put_echo(CH_NL);
		end else if (control_byte(c) && settings.flags[FL_VIS]) begin
			put_echo(CH_UP);
			put_echo((c + CTL_OFFSET) & CTL_MASK);
		end else begin
			put_echo(c);
		end
	endfunction

	function void rub_once();
		put_echo(CH_BS);
		if (settings.flags[FL_EBLANK]) begin
			put_echo(CH_SP);
			put_echo(CH_BS);
		end
	endfunction

	// steps head back over one stored byte; a visible control byte is rubbed out twice in the echo
	function void rub_out();
		logic [7:0] c;
		head = (head == 0) ? DEPTH - 1 : head - 1;
		c = ring[head];
		if (settings.flags[FL_ECHO]) begin
			rub_once();
			if (control_byte(c) && settings.flags[FL_VIS])
				rub_once();
		end
	endfunction

	function void stow(logic [7:0] c);
		ring[head] = c;
		head = step_on(head);
	endfunction

	function void queue_result(logic intr, logic rv, logic [7:0] rc, logic fin);
		res_t r;
		r.echo       = echo_now;
		r.interrupt  = intr;
		r.read_valid = rv;
		r.read_char  = rc;
		r.last       = fin;
		due_results.push_back(r);
		echo_now = '0;
	endfunction

	function void predict_discipline(logic op, logic [7:0] ch);
		logic [7:0]  c;
		logic [7:0]  rc;
		int unsigned n;
		int unsigned k;
		echo_now = '0;
		c = ch;
		if (op == OP_TAKE) begin
			if (committed > 0) begin
				rc = ring[tail];
				tail = step_on(tail);
				committed--;
				queue_result(1'b0, 1'b1, rc, 1'b1);
			end else begin
				queue_result(1'b0, 1'b0, 8'd0, 1'b1);
			end
			return;
		end
		if (settings.mode == MODE_RAW) begin
			if (committed < DEPTH) begin
				stow(c);
				committed++;
			end
			queue_result(1'b0, 1'b0, 8'd0, 1'b1);
			return;
		end
		if (c == CH_CR && settings.flags[FL_CRMAP])
			c = CH_NL;
		if (settings.flags[FL_INTR] && c == settings.intr_ch) begin
			echo_key(c);
			queue_result(1'b1, 1'b0, 8'd0, 1'b1);
			return;
		end
		if (settings.mode == MODE_CBREAK) begin
			if (committed >= DEPTH) begin
				put_echo(settings.full_ch);
			end else begin
				stow(c);
				if (settings.flags[FL_ECHO])
					echo_key(c);
				committed++;
			end
			queue_result(1'b0, 1'b0, 8'd0, 1'b1);
			return;
		end
		// line editing
		if (settings.flags[FL_KILL] && c == settings.kill_ch) begin
			n = cursor;
			if (n == 0) begin
				queue_result(1'b0, 1'b0, 8'd0, 1'b1);
			end else begin
				for (k = 0; k < n; k++) begin
					rub_out();
					cursor--;
					queue_result(1'b0, 1'b0, 8'd0, k + 1 == n);
				end
			end
			return;
		end
		if (settings.flags[FL_ERASE] && c == settings.erase_ch) begin
			if (cursor > 0) begin
				cursor--;
				rub_out();
			end
			queue_result(1'b0, 1'b0, 8'd0, 1'b1);
			return;
		end
		if (c == CH_NL || c == CH_CR || (c == settings.eof_ch && settings.flags[FL_EOF])) begin
			if (committed + cursor >= DEPTH) begin
				put_echo(settings.full_ch);
			end else begin
				if (settings.flags[FL_ECHO]) begin
					echo_key(c);
					if (c == settings.eof_ch)
						echo_key(CH_NL);
				end
				stow(c);
				committed += cursor + 1;
				cursor = 0;
			end
			queue_result(1'b0, 1'b0, 8'd0, 1'b1);
			return;
		end
		// plain byte keeps one cell free for the line end
		if (committed + cursor >= DEPTH - 1) begin
			put_echo(settings.full_ch);
		end else begin
			if (settings.flags[FL_ECHO])
				echo_key(c);
			cursor++;
			stow(c);
		end
		queue_result(1'b0, 1'b0, 8'd0, 1'b1);
	endfunction

	function void check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want) begin
			failures++;
			if (failures <= 10)
				$display("result %0d: %s expected %0d, got %0d",
					results_seen, name, want, got);
		end
	endfunction

	function void compare_result();
		res_t want;
		if (due_results.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("result %0d arrived with no item to account for it", results_seen);
			results_seen++;
			return;
		end
		want = due_results.pop_front();
		check_field("echo_count", 8'(echo_count), 8'(want.echo.cnt));
		check_field("echo_byte0", echo_byte0, want.echo.b[0]);
		check_field("echo_byte1", echo_byte1, want.echo.b[1]);
		check_field("echo_byte2", echo_byte2, want.echo.b[2]);
		check_field("echo_byte3", echo_byte3, want.echo.b[3]);
		check_field("echo_byte4", echo_byte4, want.echo.b[4]);
		check_field("echo_byte5", echo_byte5, want.echo.b[5]);
		check_field("interrupt", 8'(interrupt), 8'(want.interrupt));
		check_field("read_valid", 8'(read_valid), 8'(want.read_valid));
		check_field("read_char", read_char, want.read_char);
		check_field("last", 8'(last), 8'(want.last));
		results_seen++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				ring[i] = 8'd0;
			head      = 0;
			tail      = 0;
			committed = 0;
			cursor    = 0;
			settings.mode     = RST_MODE;
			settings.flags    = RST_FLAGS;
			settings.intr_ch  = RST_INTR;
			settings.kill_ch  = RST_KILL;
			settings.erase_ch = RST_ERASE;
			settings.eof_ch   = RST_EOF;
			settings.full_ch  = RST_FULL;
			echo_now = '0;
			due_results.delete();
			results_seen = 0;
			failures     = 0;
			pending      = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:  settings.mode     = cfg_data[1:0];
					CFG_FLAGS: settings.flags    = cfg_data;
					CFG_INTR:  settings.intr_ch  = cfg_data[7:0];
					CFG_KILL:  settings.kill_ch  = cfg_data[7:0];
					CFG_ERASE: settings.erase_ch = cfg_data[7:0];
					CFG_EOF:   settings.eof_ch   = cfg_data[7:0];
					CFG_FULL:  settings.full_ch  = cfg_data[7:0];
					default: ;
				endcase
			end
			// older results leave before a new item's results join the queue
			if (out_valid && !out_stall)
				compare_result();
			if (in_valid && !in_stall)
				predict_discipline(operation, rx_char);
			pending = due_results.size();
		end
	end

endmodule

### tb/sv/terminal_line_discipline_tb.sv
module terminal_line_discipline_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tld_pkg::*;

	localparam int unsigned DEPTH        = 64;
	localparam int          RANDOM_ITEMS = 280;
	localparam int          QUIET_LIMIT  = 2000;
	localparam int          DRAIN_CYCLES = 16;
	localparam logic [1:0]  MODE_LINE    = 2'd2;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       operation = OP_RX;
	logic [7:0] rx_char   = 8'd0;
	logic       out_stall = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [2:0] cfg_index = CFG_MODE;
	logic [8:0] cfg_data  = 9'd0;

	logic       in_stall;
	logic       out_valid;
	logic [2:0] echo_count;
	logic [7:0] echo_byte0;
	logic [7:0] echo_byte1;
	logic [7:0] echo_byte2;
	logic [7:0] echo_byte3;
	logic [7:0] echo_byte4;
	logic [7:0] echo_byte5;
	logic       interrupt;
	logic       read_valid;
	logic [7:0] read_char;
	logic       last;
	int         pending;
	int         failures;

	bit         no_idle      = 1'b0;
	int         items_sent   = 0;
	int         quiet_cycles = 0;
	logic [7:0] intr_now     = RST_INTR;
	logic [7:0] kill_now     = RST_KILL;
	logic [7:0] erase_now    = RST_ERASE;
	logic [7:0] eof_now      = RST_EOF;

	terminal_line_discipline #(
		.BUF_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.rx_char(rx_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.echo_count(echo_count),
		.echo_byte0(echo_byte0),
		.echo_byte1(echo_byte1),
		.echo_byte2(echo_byte2),
		.echo_byte3(echo_byte3),
		.echo_byte4(echo_byte4),
		.echo_byte5(echo_byte5),
		.interrupt(interrupt),
		.read_valid(read_valid),
		.read_char(read_char),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tld_checker #(
		.DEPTH(DEPTH)
	) line_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.rx_char(rx_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.echo_count(echo_count),
		.echo_byte0(echo_byte0),
		.echo_byte1(echo_byte1),
		.echo_byte2(echo_byte2),
		.echo_byte3(echo_byte3),
		.echo_byte4(echo_byte4),
		.echo_byte5(echo_byte5),
		.interrupt(interrupt),
		.read_valid(read_valid),
		.read_char(read_char),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.failures(failures)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stall before each item
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid === 1'b1 && out_stall === 1'b0))
				@(posedge clk);
			@(negedge clk);
		end
	end

	task automatic key_in(logic op, logic [7:0] ch);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		rx_char   <= ch;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [8:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic load_config(logic [1:0] m, logic [8:0] f, logic [7:0] ic, logic [7:0] kc,
			logic [7:0] ec, logic [7:0] oc, logic [7:0] fc);
		settle();
		cfg_we <= 1'b1;
		write_reg(CFG_MODE, {7'd0, m});
		write_reg(CFG_FLAGS, f);
		write_reg(CFG_INTR, {1'b0, ic});
		write_reg(CFG_KILL, {1'b0, kc});
		write_reg(CFG_ERASE, {1'b0, ec});
		write_reg(CFG_EOF, {1'b0, oc});
		write_reg(CFG_FULL, {1'b0, fc});
		cfg_we <= 1'b0;
		intr_now  = ic;
		kill_now  = kc;
		erase_now = ec;
		eof_now   = oc;
	endtask

	task automatic random_config();
		logic [1:0] m;
		logic [8:0] f;
		logic [7:0] ic, kc, ec, oc;
		case ($urandom_range(0, 4))
			0:       m = MODE_RAW;
			1:       m = MODE_CBREAK;
			default: m = MODE_LINE;
		endcase
		case ($urandom_range(0, 3))
			0:       f = RST_FLAGS;
			1:       f = 9'($urandom);
			default: f = RST_FLAGS & ~(9'd1 << $urandom_range(0, 8));
		endcase
		if ($urandom_range(0, 3) != 0) begin
			ic = RST_INTR;
			kc = RST_KILL;
			ec = $urandom_range(0, 1) ? RST_ERASE : CH_DEL;
			oc = RST_EOF;
		end else begin
			ic = 8'($urandom);
			kc = 8'($urandom);
			ec = 8'($urandom);
			oc = 8'($urandom);
		end
		load_config(m, f, ic, kc, ec, oc, 8'($urandom));
	endtask

	// mostly whole lines with edits, then reads; some noise and read bursts
	task automatic type_session(int budget);
		int stop;
		int len;
		stop = items_sent + budget;
		while (items_sent < stop) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 66)
						: $urandom_range(1, 8);
					repeat (len) begin
						case ($urandom_range(0, 24))
							0:       key_in(OP_RX, erase_now);
							1:       key_in(OP_RX, kill_now);
							default: key_in(OP_RX, 8'($urandom_range(32, 126)));
						endcase
					end
					case ($urandom_range(0, 5))
						0:       key_in(OP_RX, CH_CR);
						1:       key_in(OP_RX, eof_now);
						2:       key_in(OP_RX, kill_now);
						default: key_in(OP_RX, CH_NL);
					endcase
					repeat ($urandom_range(0, len + 2))
						key_in(OP_TAKE, 8'($urandom));
				end
				6, 7:
					repeat ($urandom_range(1, 4))
						key_in(OP_RX, ($urandom_range(0, 5) == 0) ? intr_now : 8'($urandom));
				8:
					repeat ($urandom_range(1, 8))
						key_in(OP_TAKE, 8'($urandom));
				default:
					if ($urandom_range(0, 2) == 0)
						repeat (DEPTH + 6) key_in(OP_TAKE, 8'($urandom));
					else
						repeat ($urandom_range(1, 3)) key_in(OP_RX, erase_now);
			endcase
		end
	endtask

	initial begin
		int first_random;
		int phase;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// settings as after reset
		key_in(OP_TAKE, 8'hA5);
		key_in(OP_RX, RST_INTR);
		key_in(OP_RX, 8'h61);
		key_in(OP_RX, 8'h62);
		key_in(OP_RX, RST_ERASE);
		key_in(OP_RX, RST_KILL);

		// every ring cell gets written: fill past full, drain past empty
		load_config(MODE_RAW, RST_FLAGS, RST_INTR, RST_KILL, RST_ERASE, RST_EOF, RST_FULL);
		repeat (DEPTH + 1) key_in(OP_RX, 8'($urandom));
		repeat (DEPTH + 1) key_in(OP_TAKE, 8'($urandom));

		load_config(MODE_LINE, RST_FLAGS, RST_INTR, RST_KILL, RST_ERASE, RST_EOF, RST_FULL);
		key_in(OP_RX, 8'h78);
		key_in(OP_RX, 8'h00);
		key_in(OP_RX, 8'hFF);
		key_in(OP_RX, CH_DEL);
		key_in(OP_RX, RST_ERASE);
		key_in(OP_RX, RST_ERASE);
		key_in(OP_RX, RST_KILL);
		key_in(OP_RX, RST_KILL);
		key_in(OP_RX, RST_ERASE);
		key_in(OP_RX, CH_CR);
		key_in(OP_TAKE, 8'h00);
		key_in(OP_RX, 8'h61);
		key_in(OP_RX, RST_EOF);
		key_in(OP_TAKE, 8'hFF);
		key_in(OP_TAKE, 8'h5A);
		key_in(OP_TAKE, 8'h00);

		// all flags off, special characters at the extremes
		load_config(MODE_LINE, 9'h000, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
		key_in(OP_RX, CH_CR);
		key_in(OP_RX, 8'h00);
		key_in(OP_RX, 8'hFF);
		key_in(OP_RX, CH_NL);
		key_in(OP_TAKE, 8'hC3);

		load_config(MODE_CBREAK, 9'h0FF, 8'h00, RST_KILL, RST_ERASE, RST_EOF, 8'h00);
		key_in(OP_RX, CH_CR);
		key_in(OP_RX, 8'h00);
		key_in(OP_RX, 8'h41);

		first_random = items_sent;
		phase = 0;
		while (items_sent - first_random < RANDOM_ITEMS) begin
			random_config();
			no_idle = ($urandom_range(0, 3) == 0);
			type_session(20);
			if (phase == 2)
				settle();
			type_session(20);
			phase++;
		end
		no_idle = 1'b0;
		settle();

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
